FILE: design/env_sensor_compensation_top_macros.svh
// Assertion helpers for env_sensor_compensation_top.
`ifndef ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ESC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("esc: implication check failed");

// Next-cycle implication, checked outside reset.
`define ESC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("esc: next-cycle check failed");

`endif

FILE: design/esc_pkg.sv
`timescale 1ns / 1ps
package esc_pkg;

  typedef enum logic [2:0] {
    CFG_TEMP_CAL    = 3'd0,
    CFG_PRESS_CAL_A = 3'd1,
    CFG_PRESS_CAL_B = 3'd2,
    CFG_PRESS_CAL_C = 3'd3,
    CFG_HUMI_CAL    = 3'd4,
    CFG_TEMP_ADJUST = 3'd5,
    CFG_HUMI_GAIN   = 3'd6,
    CFG_HUMI_OFFSET = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] temp_cal;
    logic [47:0] press_cal_a;
    logic [47:0] press_cal_b;
    logic [47:0] press_cal_c;
    logic [63:0] humi_cal;
    logic [31:0] temp_adjust;
    logic [31:0] humi_gain;
    logic [14:0] humi_offset;
  } esc_cal_t;

  localparam int FINE_LAT  = 4;
  localparam int TEMP_LAT  = 3;
  localparam int HUMI_LAT  = 13;
  localparam int DIV_STEPS = 32;
  localparam int PRESS_LAT = 9 + DIV_STEPS + 5;
  localparam int TOTAL_LAT = FINE_LAT + PRESS_LAT;
  localparam int HUMI_DLY  = PRESS_LAT - HUMI_LAT;
  localparam int TEMP_DLY  = PRESS_LAT - TEMP_LAT;

  localparam logic [31:0] TEMP_ADJ_RST   = 32'd8192;
  localparam logic [31:0] HUMI_GAIN_RST  = 32'd102400;
  localparam logic [31:0] HUMI_BASE      = 32'd76800;
  localparam logic [31:0] PRESS_BASE     = 32'd64000;
  localparam logic [31:0] PRESS_FULL     = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE    = 32'd3125;
  localparam logic [31:0] HUMI_OFF_SCALE = 32'd41943;
  localparam logic [31:0] HUMI_MAX       = 32'd9999;
  localparam logic [31:0] SIGN_BIT       = 32'h8000_0000;
  localparam logic [31:0] HUMI_INNER_ADD = 32'd2097152;
  localparam logic [31:0] HUMI_ROUND     = 32'd8192;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] x);
    return {{20{x[11]}}, x};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] x);
    return {{24{x[7]}}, x};
  endfunction

  function automatic logic [31:0] sx15(input logic [14:0] x);
    return {{17{x[14]}}, x};
  endfunction

endpackage

FILE: design/esc_fine.sv
`timescale 1ns / 1ps
module esc_fine
  import esc_pkg::*;
(
  input  logic        clk,
  input  esc_cal_t    cal,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_press,
  input  logic [15:0] raw_humi,
  output logic [31:0] fine,
  output logic [19:0] press_out,
  output logic [15:0] humi_out
);

  logic [31:0] t1, t2, t3;
  logic [31:0] x1_r, d_r, m1_r, dd_r, a_r, e_r, fine_r;
  logic [19:0] p_r [FINE_LAT];
  logic [15:0] h_r [FINE_LAT];

  assign t1 = {16'd0, cal.temp_cal[15:0]};
  assign t2 = sx16(cal.temp_cal[31:16]);
  assign t3 = sx16(cal.temp_cal[47:32]);

  always_ff @(posedge clk) begin
    x1_r   <= {15'd0, raw_temp[19:3]} - (t1 << 1);
    d_r    <= {16'd0, raw_temp[19:4]} - t1;
    m1_r   <= x1_r * t2;
    dd_r   <= d_r * d_r;
    a_r    <= asr32(m1_r, 11);
    e_r    <= asr32(dd_r, 12) * t3;
    fine_r <= a_r + asr32(e_r, 14);
    p_r[0] <= raw_press;
    h_r[0] <= raw_humi;
    for (int i = 1; i < FINE_LAT; i++) begin
      p_r[i] <= p_r[i-1];
      h_r[i] <= h_r[i-1];
    end
  end

  assign fine      = fine_r;
  assign press_out = p_r[FINE_LAT-1];
  assign humi_out  = h_r[FINE_LAT-1];

endmodule

FILE: design/esc_humi.sv
`timescale 1ns / 1ps
module esc_humi
  import esc_pkg::*;
(
  input  logic        clk,
  input  esc_cal_t    cal,
  input  logic [31:0] fine,
  input  logic [15:0] raw_humi,
  output logic [13:0] humidity
);

  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic [31:0] h_r, adc_r, p5_r, p6_r, p3_r, a0_r;
  logic [31:0] left_r [3:10];
  logic [31:0] i1_r, i2_r, i3_r, inner_r, i4_r, right_r;
  logic [31:0] hv8_r, hv9_r, hv10_r, qq_r, s_r, hf_r, zm_r;
  logic [31:0] q;
  logic [63:0] prod_r;
  logic        neg_r;
  logic [13:0] hum_r;

  assign h1 = {24'd0, cal.humi_cal[7:0]};
  assign h2 = sx16(cal.humi_cal[23:8]);
  assign h3 = {24'd0, cal.humi_cal[31:24]};
  assign h4 = sx12(cal.humi_cal[43:32]);
  assign h5 = sx12(cal.humi_cal[55:44]);
  assign h6 = sx8(cal.humi_cal[63:56]);
  assign q  = asr32(hv8_r, 15);

  always_ff @(posedge clk) begin
    zm_r      <= sx15(cal.humi_offset) * HUMI_OFF_SCALE;
    h_r       <= fine - HUMI_BASE;
    adc_r     <= {16'd0, raw_humi};
    p5_r      <= h5 * h_r;
    p6_r      <= h_r * h6;
    p3_r      <= h_r * h3;
    a0_r      <= (adc_r << 14) - (h4 << 20) + 32'd16384;
    left_r[3] <= asr32(a0_r - p5_r, 15);
    i1_r      <= asr32(p6_r, 10);
    i2_r      <= asr32(p3_r, 11) + 32'd32768;
    for (int i = 4; i <= 10; i++) left_r[i] <= left_r[i-1];
    i3_r      <= i1_r * i2_r;
    inner_r   <= asr32(i3_r, 10) + HUMI_INNER_ADD;
    i4_r      <= inner_r * h2;
    right_r   <= asr32(i4_r + HUMI_ROUND, 14);
    hv8_r     <= left_r[7] * right_r;
    hv9_r     <= hv8_r;
    qq_r      <= q * q;
    hv10_r    <= hv9_r;
    s_r       <= asr32(qq_r, 7) * h1;
    hf_r      <= hv10_r - asr32(s_r, 4) + zm_r;
    prod_r    <= {32'd0, hf_r} * {32'd0, cal.humi_gain};
    neg_r     <= hf_r[31];
    if (neg_r) begin
      hum_r <= '0;
    end else if (prod_r[63:32] > HUMI_MAX) begin
      hum_r <= HUMI_MAX[13:0];
    end else begin
      hum_r <= prod_r[45:32];
    end
  end

  assign humidity = hum_r;

endmodule

FILE: design/esc_press.sv
`timescale 1ns / 1ps
module esc_press
  import esc_pkg::*;
(
  input  logic        clk,
  input  esc_cal_t    cal,
  input  logic [31:0] fine,
  input  logic [19:0] raw_press,
  output logic [31:0] pressure
);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] dv;
    logic        dbl;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t s);
    div_st_t     o;
    logic [32:0] t;
    t = {s.rem, s.num[31]};
    o = s;
    if (t >= {1'b0, s.dv}) begin
      o.rem = 32'(t - {1'b0, s.dv});
      o.num = {s.num[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.num = {s.num[30:0], 1'b0};
    end
    return o;
  endfunction

  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [19:0] adc_r [1:6];
  logic [31:0] v1_r, q_r, qq_r, m5_r, m2_r, a11_r, a13_r, m2s_r, m5s_r, m5s4_r, m2s4_r;
  logic [31:0] v2a_r, m3_r, v2b_r, v1b_r, v2b6_r, v1c_r, dv_r, vpre_r, vm_r, dv8_r;
  div_st_t     ds0_r;
  div_st_t     ds_r [DIV_STEPS];
  logic [31:0] v_r, pp_r, m8_r, v11_r, mm9_r, w2_r, v12_r, s_r, v13_r, out_r;
  logic        z_r, z11_r, z12_r, z13_r;
  logic [31:0] quo;

  assign p1 = {16'd0, cal.press_cal_a[15:0]};
  assign p2 = sx16(cal.press_cal_a[31:16]);
  assign p3 = sx16(cal.press_cal_a[47:32]);
  assign p4 = sx16(cal.press_cal_b[15:0]);
  assign p5 = sx16(cal.press_cal_b[31:16]);
  assign p6 = sx16(cal.press_cal_b[47:32]);
  assign p7 = sx16(cal.press_cal_c[15:0]);
  assign p8 = sx16(cal.press_cal_c[31:16]);
  assign p9 = sx16(cal.press_cal_c[47:32]);
  assign quo = ds_r[DIV_STEPS-1].num;

  always_ff @(posedge clk) begin
    adc_r[1] <= raw_press;
    for (int i = 2; i <= 6; i++) adc_r[i] <= adc_r[i-1];
    v1_r   <= asr32(fine, 1) - PRESS_BASE;
    q_r    <= asr32(asr32(fine, 1) - PRESS_BASE, 2);
    qq_r   <= q_r * q_r;
    m5_r   <= v1_r * p5;
    m2_r   <= p2 * v1_r;
    a11_r  <= asr32(qq_r, 11);
    a13_r  <= asr32(qq_r, 13);
    m2s_r  <= asr32(m2_r, 1);
    m5s_r  <= m5_r << 1;
    v2a_r  <= a11_r * p6;
    m3_r   <= p3 * a13_r;
    m5s4_r <= m5s_r;
    m2s4_r <= m2s_r;
    v2b_r  <= asr32(v2a_r + m5s4_r, 2) + (p4 << 16);
    v1b_r  <= asr32(asr32(m3_r, 3) + m2s4_r, 18) + 32'd32768;
    v1c_r  <= v1b_r * p1;
    v2b6_r <= v2b_r;
    dv_r   <= asr32(v1c_r, 15);
    vpre_r <= (PRESS_FULL - {12'd0, adc_r[6]}) - asr32(v2b6_r, 12);
    vm_r   <= vpre_r * PRESS_SCALE;
    dv8_r  <= dv_r;
    ds0_r.rem <= '0;
    ds0_r.dv  <= dv8_r;
    if (vm_r < SIGN_BIT) begin
      ds0_r.num <= vm_r << 1;
      ds0_r.dbl <= 1'b0;
    end else begin
      ds0_r.num <= vm_r;
      ds0_r.dbl <= 1'b1;
    end
    ds_r[0] <= div_step(ds0_r);
    for (int i = 1; i < DIV_STEPS; i++) ds_r[i] <= div_step(ds_r[i-1]);
    v_r   <= ds_r[DIV_STEPS-1].dbl ? (quo << 1) : quo;
    z_r   <= (ds_r[DIV_STEPS-1].dv == '0);
    pp_r  <= {3'd0, v_r[31:3]} * {3'd0, v_r[31:3]};
    m8_r  <= {2'd0, v_r[31:2]} * p8;
    v11_r <= v_r;
    z11_r <= z_r;
    mm9_r <= p9 * (pp_r >> 13);
    w2_r  <= asr32(m8_r, 13);
    v12_r <= v11_r;
    z12_r <= z11_r;
    s_r   <= asr32(mm9_r, 12) + w2_r + p7;
    v13_r <= v12_r;
    z13_r <= z12_r;
    out_r <= z13_r ? '0 : v13_r + asr32(s_r, 4);
  end

  assign pressure = out_r;

endmodule

FILE: design/env_sensor_compensation_top.sv
`timescale 1ns / 1ps
// Environmental sensor compensation pipeline.
// Input: pulse start with in_raw_temp, in_raw_press and in_raw_humi; the item is
// taken on a clock edge where start is high and busy is low.
// Output: out_valid is high for one cycle with out_temperature (0.01 C),
// out_humidity (0.01 %RH, 0..9999) and out_pressure (Pa, 0 on a zero divisor).
// Pipeline: 4 fine-temperature stages, then 46 pressure stages, 32 of them the
// one-bit-per-stage divider; temperature and humidity are delayed to match.
// Throughput: one item per clock while busy is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no item is in flight.
// Reset: calibration clears, gains and offset take their defaults, all items in
// flight are dropped; busy is high during reset and the cycle after.
// The receiver cannot stall: results appear on their fixed cycle.
module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_raw_temp,
  input  logic [19:0]        in_raw_press,
  input  logic [15:0]        in_raw_humi,
  output logic               out_valid,
  output logic signed [15:0] out_temperature,
  output logic [13:0]        out_humidity,
  output logic [31:0]        out_pressure,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  `include "env_sensor_compensation_top_macros.svh"

  esc_cal_t    cal_r;
  logic        busy_r;
  logic        vld_r [TOTAL_LAT];
  logic [31:0] fine;
  logic [19:0] press_d;
  logic [15:0] humi_d;
  logic [13:0] hum;
  logic [31:0] t_r, tg_r;
  logic [15:0] temp_r;
  logic [15:0] tdly_r [TEMP_DLY];
  logic [13:0] hdly_r [HUMI_DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r            <= 1'b1;
      cal_r.temp_cal    <= '0;
      cal_r.press_cal_a <= '0;
      cal_r.press_cal_b <= '0;
      cal_r.press_cal_c <= '0;
      cal_r.humi_cal    <= '0;
      cal_r.temp_adjust <= TEMP_ADJ_RST;
      cal_r.humi_gain   <= HUMI_GAIN_RST;
      cal_r.humi_offset <= '0;
      for (int i = 0; i < TOTAL_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      vld_r[0] <= start && !busy_r;
      for (int i = 1; i < TOTAL_LAT; i++) vld_r[i] <= vld_r[i-1];
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TEMP_CAL:    cal_r.temp_cal    <= cfg_data[47:0];
          CFG_PRESS_CAL_A: cal_r.press_cal_a <= cfg_data[47:0];
          CFG_PRESS_CAL_B: cal_r.press_cal_b <= cfg_data[47:0];
          CFG_PRESS_CAL_C: cal_r.press_cal_c <= cfg_data[47:0];
          CFG_HUMI_CAL:    cal_r.humi_cal    <= cfg_data;
          CFG_TEMP_ADJUST: cal_r.temp_adjust <= cfg_data[31:0];
          CFG_HUMI_GAIN:   cal_r.humi_gain   <= cfg_data[31:0];
          CFG_HUMI_OFFSET: cal_r.humi_offset <= cfg_data[14:0];
        endcase
      end
    end
  end

  esc_fine u_fine (
    .clk       (clk),
    .cal       (cal_r),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .raw_humi  (in_raw_humi),
    .fine      (fine),
    .press_out (press_d),
    .humi_out  (humi_d)
  );

  esc_humi u_humi (
    .clk      (clk),
    .cal      (cal_r),
    .fine     (fine),
    .raw_humi (humi_d),
    .humidity (hum)
  );

  esc_press u_press (
    .clk       (clk),
    .cal       (cal_r),
    .fine      (fine),
    .raw_press (press_d),
    .pressure  (out_pressure)
  );

  always_ff @(posedge clk) begin
    t_r       <= asr32(fine * 32'd5 + 32'd128, 8);
    tg_r      <= t_r * {16'd0, cal_r.temp_adjust[15:0]};
    temp_r    <= 16'((tg_r >> 13) + sx16(cal_r.temp_adjust[31:16]));
    tdly_r[0] <= temp_r;
    for (int i = 1; i < TEMP_DLY; i++) tdly_r[i] <= tdly_r[i-1];
    hdly_r[0] <= hum;
    for (int i = 1; i < HUMI_DLY; i++) hdly_r[i] <= hdly_r[i-1];
  end

  assign busy            = busy_r;
  assign cfg_ready       = 1'b1;
  assign out_valid       = vld_r[TOTAL_LAT-1];
  assign out_temperature = $signed(tdly_r[TEMP_DLY-1]);
  assign out_humidity    = hdly_r[HUMI_DLY-1];

  `ESC_ASSERT_IMPL(a_out_latency, out_valid, $past(start && !busy, TOTAL_LAT))
  `ESC_ASSERT_IMPL(a_humi_range, out_valid, out_humidity <= HUMI_MAX[13:0])
  `ESC_ASSERT_NEXT(a_accept_enters, start && !busy, vld_r[0])

endmodule
